### hw/rtl/abs_ma_pkg.sv
// shared constants and a helper of the absolute-value moving average block
package abs_ma_pkg;

	// item field widths
	localparam int SAMPLE_W = 32;
	localparam int MAG_W = 31;

	// window register
	localparam int WIN_CFG_W = 11;
	localparam int MAX_WINDOW_DEF = 1024;
	localparam int WINDOW_RESET = 10;
	localparam int WINDOW_MIN = 2;

	// register port
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_WINDOW = 1'b0;

	// absolute value, the most negative sample saturates to all ones
	function automatic logic [MAG_W-1:0] sat_abs(input logic signed [SAMPLE_W-1:0] s);
		logic [SAMPLE_W-1:0] neg;
		neg = 32'd0 - s;
		if (!s[SAMPLE_W-1]) begin
			sat_abs = s[MAG_W-1:0];
		end else if (neg[SAMPLE_W-1]) begin
			sat_abs = {MAG_W{1'b1}};
		end else begin
			sat_abs = neg[MAG_W-1:0];
		end
	endfunction

endpackage

### hw/rtl/abs_ma_if.sv
// valid/ready channels for sample and average items
interface abs_ma_sample_if;
	logic valid;
	logic ready;
	logic signed [abs_ma_pkg::SAMPLE_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface abs_ma_average_if;
	logic valid;
	logic ready;
	logic [abs_ma_pkg::MAG_W-1:0] average;

	modport source (output valid, output average, input ready);
	modport sink (input valid, input average, output ready);
endinterface

### hw/rtl/abs_ma_ring.sv
// history ring memory, one write and one registered read port
module abs_ma_ring #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 31
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### hw/rtl/abs_ma_div.sv
// restoring divider, one quotient bit per cycle
module abs_ma_div #(
	parameter int DIVIDEND_W = 41,
	parameter int DIVISOR_W = 11
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  done,
	output logic [DIVIDEND_W-1:0] quotient
);

	localparam int STEP_W = $clog2(DIVIDEND_W + 1);

	logic                  busy_q;
	logic                  done_q;
	logic [STEP_W-1:0]     step_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  dvs_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W:0]    shifted;
	logic [DIVISOR_W:0]    diff;
	logic                  borrow;

	// trial subtract of the divisor from the shifted remainder
	always_comb begin
		shifted = {rem_q, quo_q[DIVIDEND_W-1]};
		diff = shifted - {1'b0, dvs_q};
		borrow = (shifted < {1'b0, dvs_q});
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == STEP_W'(DIVIDEND_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// datapath: quotient bits shift in where dividend bits shift out
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= borrow ? shifted[DIVISOR_W-1:0] : diff[DIVISOR_W-1:0];
			quo_q <= {quo_q[DIVIDEND_W-2:0], ~borrow};
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule

### hw/rtl/abs_moving_average_top.sv
// moving average of absolute sample values with a ring history and serial divider
// an accepted sample passes the update state and the divider before the average is valid
// one item at a time, held by the one-bit-per-cycle divider over the SUM_W-bit
//   running sum and by a still full output register; not ready meanwhile
// the output register lets a result wait while the next sample is taken
// reset: window 10, ring position, fill count and sum cleared; history left as is
module abs_moving_average_top #(
	parameter int MAX_WINDOW = abs_ma_pkg::MAX_WINDOW_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	abs_ma_sample_if.sink                     sample_ch,
	abs_ma_average_if.source                  average_ch,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [abs_ma_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [abs_ma_pkg::APB_DATA_W-1:0] pwdata,
	output logic [abs_ma_pkg::APB_DATA_W-1:0] prdata,
	output logic                              pready
);

	import abs_ma_pkg::*;

	localparam int IDX_W = $clog2(MAX_WINDOW);
	localparam int CNT_W = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W = MAG_W + IDX_W;
	localparam int WIN_RST = (WINDOW_RESET > MAX_WINDOW) ? MAX_WINDOW : WINDOW_RESET;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_UPD  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_HOLD = 2'd3;

	logic [1:0]           state_q;
	logic [CNT_W-1:0]     window_q;
	logic [IDX_W-1:0]     wr_idx_q;
	logic [CNT_W-1:0]     fill_q;
	logic [SUM_W-1:0]     sum_q;
	logic [MAG_W-1:0]     mag_q;
	logic                 avg_valid_q;
	logic [MAG_W-1:0]     avg_q;

	logic                 accept;
	logic                 cfg_wr;
	logic [WIN_CFG_W-1:0] cfg_val;
	logic [CNT_W-1:0]     cfg_win;
	logic                 full;
	logic [MAG_W-1:0]     old_mag;
	logic [SUM_W-1:0]     sum_next;
	logic [CNT_W-1:0]     fill_next;
	logic [CNT_W-1:0]     idx_inc;
	logic [IDX_W-1:0]     idx_next;
	logic                 out_free;
	logic                 upd;
	logic [MAG_W-1:0]     rd_data;
	logic                 div_done;
	logic [SUM_W-1:0]     div_quo;

	// handshakes
	assign accept = sample_ch.valid && sample_ch.ready;
	assign sample_ch.ready = (state_q == ST_IDLE);
	assign out_free = !avg_valid_q || average_ch.ready;
	assign upd = (state_q == ST_UPD);
	assign average_ch.valid = avg_valid_q;
	assign average_ch.average = avg_q;

	// register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_WINDOW);
	assign cfg_val = pwdata[WIN_CFG_W-1:0];
	assign prdata = (paddr[2] == REG_WINDOW) ? APB_DATA_W'(window_q) : '0;

	// clamp the written window into the legal range
	always_comb begin
		if (cfg_val < WIN_CFG_W'(WINDOW_MIN)) begin
			cfg_win = CNT_W'(WINDOW_MIN);
		end else if (32'(cfg_val) > 32'(MAX_WINDOW)) begin
			cfg_win = CNT_W'(MAX_WINDOW);
		end else begin
			cfg_win = CNT_W'(cfg_val);
		end
	end

	// running sum update, oldest entry drops out once the window is full
	always_comb begin
		full = (fill_q == window_q);
		old_mag = full ? rd_data : '0;
		sum_next = sum_q + SUM_W'(mag_q) - SUM_W'(old_mag);
		fill_next = full ? fill_q : fill_q + 1'b1;
		idx_inc = CNT_W'(wr_idx_q) + 1'b1;
		idx_next = (idx_inc >= window_q) ? '0 : idx_inc[IDX_W-1:0];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q) inside
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					state_q <= ST_DIV;
				end
				ST_DIV, ST_HOLD: begin
					if (div_done) begin
						state_q <= out_free ? ST_IDLE : ST_HOLD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= CNT_W'(WIN_RST);
			wr_idx_q <= '0;
			fill_q <= '0;
			sum_q <= '0;
		end else if (cfg_wr) begin
			window_q <= cfg_win;
			wr_idx_q <= '0;
			fill_q <= '0;
			sum_q <= '0;
		end else if (upd) begin
			wr_idx_q <= idx_next;
			fill_q <= fill_next;
			sum_q <= sum_next;
		end
	end

	// captured magnitude of the accepted item
	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q <= sat_abs(sample_ch.sample);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_valid_q <= 1'b0;
		end else if ((state_q == ST_DIV || state_q == ST_HOLD) && div_done && out_free) begin
			avg_valid_q <= 1'b1;
		end else if (average_ch.ready) begin
			avg_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DIV || state_q == ST_HOLD) && div_done && out_free) begin
			avg_q <= div_quo[MAG_W-1:0];
		end
	end

	abs_ma_ring #(
		.DEPTH (MAX_WINDOW),
		.WIDTH (MAG_W)
	) u_ring (
		.clk     (clk),
		.wr_en   (upd),
		.wr_addr (wr_idx_q),
		.wr_data (mag_q),
		.rd_en   (accept),
		.rd_addr (wr_idx_q),
		.rd_data (rd_data)
	);

	abs_ma_div #(
		.DIVIDEND_W (SUM_W),
		.DIVISOR_W  (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (upd),
		.dividend (sum_next),
		.divisor  (fill_next),
		.done     (div_done),
		.quotient (div_quo)
	);

	// checks
	a_fill_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= window_q)
		else $error("fill count exceeds window");

	a_idx_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_W'(wr_idx_q) < window_q)
		else $error("ring position outside window");

	a_accept_to_update: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_UPD))
		else $error("accepted item did not reach update");

	a_div_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD) |=> !div_done)
		else $error("divider done right after start");

endmodule

### test/abs_moving_average_top_tb.sv
// self-checking testbench for the absolute-value moving average block
module abs_moving_average_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import abs_ma_pkg::*;

	localparam logic [APB_ADDR_W-1:0] WINDOW_ADDR = 3'd0;
	localparam logic [APB_ADDR_W-1:0] SPARE_ADDR = 3'd4;
	localparam int SETTLE_CYCLES = 60;
	localparam int HOLD_AT = 400;
	localparam int HOLD_CYCLES = 800;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	abs_ma_sample_if sample_ch ();
	abs_ma_average_if average_ch ();

	abs_moving_average_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_ch(sample_ch),
		.average_ch(average_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// samples waiting to be offered and averages waiting to come out
	logic signed [SAMPLE_W-1:0] pending_samples[$];
	logic [MAG_W-1:0] expected_avg[$];

	// shadow of the filter state
	logic [MAG_W-1:0] history[MAX_WINDOW_DEF];
	int unsigned ring_pos = 0;
	int unsigned fill_cnt = 0;
	int unsigned win_len = WINDOW_RESET;
	logic [63:0] abs_sum = '0;

	int sender_idle_pct = 20;
	int sink_stall_pct = 20;
	int n_taken = 0;
	int hold_left = 0;
	logic hold_done = 1'b0;
	logic sample_fire = 1'b0;
	logic error_seen = 1'b0;

	// absolute value into the ring, returns the new mean
	function automatic logic [MAG_W-1:0] update_average(input logic [SAMPLE_W-1:0] s);
		logic [SAMPLE_W-1:0] flipped;
		logic [MAG_W-1:0] mag;
		logic [63:0] quot;
		if (s[SAMPLE_W-1]) begin
			flipped = ~s + 1'b1;
			mag = flipped[SAMPLE_W-1] ? {MAG_W{1'b1}} : flipped[MAG_W-1:0];
		end else begin
			mag = s[MAG_W-1:0];
		end
		if (ring_pos >= win_len) ring_pos = 0;
		if (fill_cnt >= win_len) begin
			abs_sum = abs_sum - history[ring_pos] + mag;
		end else begin
			abs_sum = abs_sum + mag;
			fill_cnt++;
		end
		history[ring_pos] = mag;
		ring_pos = (ring_pos + 1 >= win_len) ? 0 : ring_pos + 1;
		quot = abs_sum / fill_cnt;
		return quot[MAG_W-1:0];
	endfunction

	// window write clamps the length and restarts the ramp
	function automatic void apply_window(input logic [APB_DATA_W-1:0] data);
		int unsigned v;
		v = data[WIN_CFG_W-1:0];
		if (v < WINDOW_MIN) v = WINDOW_MIN;
		else if (v > MAX_WINDOW_DEF) v = MAX_WINDOW_DEF;
		win_len = v;
		ring_pos = 0;
		fill_cnt = 0;
		abs_sum = '0;
	endfunction

	// full-range values half the time, with extremes and small magnitudes mixed in
	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(9))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return $signed($urandom_range(32)) - 16;
			3: return '0;
			4: return 32'sh8000_0001;
			default: return $signed($urandom());
		endcase
	endfunction

	// clock
	initial begin
		forever #10 clk = ~clk;
	end

	// timeout
	initial begin
		#20_000_000;
		$display("[abs_moving_average_top] ERROR");
		$finish;
	end

	// sample driver
	always @(negedge clk) begin
		if (!arst_n) begin
			sample_ch.valid <= 1'b0;
			sample_ch.sample <= '0;
		end else if (sample_ch.valid && !sample_fire) begin
			sample_ch.valid <= 1'b1;
		end else if (pending_samples.size() != 0 &&
				$urandom_range(99) >= sender_idle_pct) begin
			sample_ch.valid <= 1'b1;
			sample_ch.sample <= pending_samples.pop_front();
		end else begin
			sample_ch.valid <= 1'b0;
		end
	end

	// predict on every accepted item
	always @(posedge clk) begin
		sample_fire <= sample_ch.valid && sample_ch.ready;
		if (arst_n && sample_ch.valid && sample_ch.ready) begin
			expected_avg.push_back(update_average(sample_ch.sample));
			n_taken++;
		end
	end

	// result ready, with one long hold-off while samples keep coming
	always @(negedge clk) begin
		if (!arst_n) begin
			average_ch.ready <= 1'b0;
		end else if (hold_left != 0) begin
			average_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && n_taken >= HOLD_AT) begin
			average_ch.ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			average_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// compare each average against the oldest prediction
	always @(posedge clk) begin
		logic [MAG_W-1:0] want;
		if (arst_n && average_ch.valid && average_ch.ready) begin
			if (expected_avg.size() == 0) begin
				$display("%0t: unexpected average, expected none, actual %0d",
					$time, average_ch.average);
				error_seen = 1'b1;
			end else begin
				want = expected_avg.pop_front();
				if (average_ch.average !== want) begin
					$display("%0t: average mismatch, expected %0d, actual %0d",
						$time, want, average_ch.average);
					error_seen = 1'b1;
				end
			end
		end
	end

	// wait until every item is through and the block has settled
	task automatic drain();
		while (pending_samples.size() != 0 || sample_ch.valid || expected_avg.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// register write: setup then access, shadow updated at the write edge
	task automatic reg_write(input logic [APB_ADDR_W-1:0] addr,
			input logic [APB_DATA_W-1:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if ((addr >> 2) == REG_WINDOW) apply_window(data);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// one register write, normally of the window, followed by random samples
	task automatic run_phase(input logic [APB_ADDR_W-1:0] addr,
			input logic [APB_DATA_W-1:0] data, input int count,
			input int idle_pct, input int stall_pct);
		drain();
		sender_idle_pct = idle_pct;
		sink_stall_pct = stall_pct;
		reg_write(addr, data);
		repeat (count) pending_samples.push_back(pick_sample());
	endtask

	// stimulus
	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed items at the reset window, ending with a full saturated window
		pending_samples.push_back(32'sh0000_0000);
		pending_samples.push_back(32'sh0000_0001);
		pending_samples.push_back(32'shffff_ffff);
		pending_samples.push_back(32'sh7fff_ffff);
		pending_samples.push_back(32'sh8000_0000);
		pending_samples.push_back(32'sh8000_0001);
		pending_samples.push_back(32'sh5555_5555);
		pending_samples.push_back(32'shaaaa_aaaa);
		pending_samples.push_back(32'sh0000_0002);
		pending_samples.push_back(32'shffff_fffd);
		repeat (10) pending_samples.push_back(32'sh8000_0000);
		pending_samples.push_back(32'sh7fff_ffff);

		// write to an unused index keeps the running state
		run_phase(SPARE_ADDR, 32'd3, 10, 20, 20);
		// below the minimum, taken as two
		run_phase(WINDOW_ADDR, 32'd0, 40, 20, 20);
		run_phase(WINDOW_ADDR, 32'd1, 20, 20, 20);
		run_phase(WINDOW_ADDR, 32'd2, 30, 20, 20);
		run_phase(WINDOW_ADDR, 32'd3, 30, 20, 20);
		// upper bits of the write data are dropped
		run_phase(WINDOW_ADDR, 32'hffff_f805, 30, 20, 20);
		// stretch with no idling on either side
		run_phase(WINDOW_ADDR, 32'd17, 60, 0, 0);
		run_phase(WINDOW_ADDR, 32'd1024, 20, 20, 20);
		// above the maximum, taken as the full ring, run past one wrap
		run_phase(WINDOW_ADDR, 32'h0000_07ff, 1036, 20, 20);
		run_phase(WINDOW_ADDR, 32'd7, 30, 20, 20);

		drain();
		if (!error_seen) begin
			$display("[abs_moving_average_top] OK");
		end else begin
			$display("[abs_moving_average_top] ERROR");
		end
		$finish;
	end

endmodule

### filelist.f
hw/rtl/abs_ma_pkg.sv
hw/rtl/abs_ma_if.sv
hw/rtl/abs_ma_ring.sv
hw/rtl/abs_ma_div.sv
hw/rtl/abs_moving_average_top.sv
test/abs_moving_average_top_tb.sv
